// ----- rtl/fbyp_pkg.sv -----
// ---------------------------------------------------------------------------
// fbyp_pkg : shared constants for the FIR filter with bypass
// Sample conversion constants, output scaling and parameter defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package fbyp_pkg;

  // parameter defaults
  localparam int TAPS_DEF      = 64;
  localparam int ACC_SHIFT_DEF = 15;
  localparam int Y_FRAC_DEF    = 12;

  // field widths
  localparam int SMP_W  = 12;
  localparam int IDX_W  = 6;
  localparam int COEF_W = 16;
  localparam int DAC_W  = 16;

  // sample to fixed point: floor(smp * 135168 / 20475) - 13516
  localparam int X_MUL = 135168;
  localparam int X_DIV = 20475;
  localparam int X_OFS = 13516;
  localparam int NUM_W = 30;
  localparam int Q_W   = 15;

  // output scaling
  localparam int DAC_GAIN = 1240;
  localparam int DAC_MID  = 2048;

  // request types
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

endpackage
`default_nettype wire

// ----- rtl/fbyp_in_if.sv -----
// ---------------------------------------------------------------------------
// fbyp_in_if : input request channel
// Valid/ready channel carrying samples and coefficient writes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface fbyp_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [11:0]                sample;
  logic [5:0]                 coef_index;
  logic signed [15:0]         coef_value;

  modport source (output valid, req_type, sample, coef_index, coef_value, input ready);
  modport sink   (input valid, req_type, sample, coef_index, coef_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/fbyp_out_if.sv -----
// ---------------------------------------------------------------------------
// fbyp_out_if : result channel
// Valid/ready channel carrying DAC codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface fbyp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] dac_value;

  modport source (output valid, dac_value, input ready);
  modport sink   (input valid, dac_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/fir_filter_with_bypass.sv -----
// ---------------------------------------------------------------------------
// fir_filter_with_bypass : FIR filter with bypass
// Converts 12-bit samples to DAC codes, directly or through a TAPS-tap FIR.
// ---------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  in_ch   | in  | valid/ready       | req_type, sample, coef_index, coef_value
//  out_ch  | out | valid/ready       | dac_value
//  cfg_*   | in  | cfg_we, no ready  | cfg_wdata = bypass_mode
//
// Coefficient writes are done at the input transfer; bypass samples go to
// the output register; filtered samples pass the bit-serial conversion,
// one tap per cycle through the delay and coefficient RAM read ports,
// pipeline drain and output scaling. One item is in work at a time; a
// new item is taken while a result waits in the output register. Reset
// is synchronous; the delay line is cleared logically by a fill count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fir_filter_with_bypass #(
  parameter int TAPS      = fbyp_pkg::TAPS_DEF,
  parameter int ACC_SHIFT = fbyp_pkg::ACC_SHIFT_DEF,
  parameter int Y_FRAC    = fbyp_pkg::Y_FRAC_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  fbyp_in_if.sink    in_ch,
  fbyp_out_if.source out_ch,
  input  wire        cfg_we,
  input  wire        cfg_wdata
);
  import fbyp_pkg::*;

  localparam int AW    = $clog2(TAPS);
  localparam int CW    = $clog2(TAPS + 2);
  localparam int FW    = $clog2(TAPS + 1);
  localparam int ACC_W = 64;
  localparam int P_W   = 28;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_MAC   = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;
  localparam logic [2:0] ST_RND   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]               state_r, state_nxt;
  logic                     bypass_r;
  logic [Q_W-1:0]           rem_r, rem_nxt;
  logic [Q_W-1:0]           num_r, num_nxt;
  logic [3:0]               dcnt_r, dcnt_nxt;
  logic [AW-1:0]            wptr_r, wptr_nxt;
  logic [AW-1:0]            rptr_r, rptr_nxt;
  logic [FW-1:0]            fill_r, fill_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic                     v1_r, live1_r, v2_r;
  logic signed [31:0]       prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [P_W-1:0]    p_r;
  logic [DAC_W-1:0]         res_r, res_nxt;
  logic                     out_valid_r;
  logic [DAC_W-1:0]         out_data_r;

  logic                     in_xfer;
  logic [NUM_W-1:0]         num_full;
  logic [Q_W:0]             rem_sh;
  logic                     rem_ge;
  logic signed [15:0]       x_val;
  logic                     coef_we;
  logic [AW-1:0]            coef_raddr;
  logic [COEF_W-1:0]        coef_rdata, dly_rdata;
  logic                     dly_we;
  logic signed [ACC_W-1:0]  acc_sh;
  logic signed [15:0]       y_val;
  logic signed [P_W-1:0]    p_bias;
  logic signed [P_W-1:0]    p_div;
  logic                     out_free;

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.dac_value = out_data_r;
  assign out_free      = !out_valid_r || out_ch.ready;

  assign num_full = NUM_W'(in_ch.sample) * NUM_W'(X_MUL);
  assign rem_sh   = {rem_r, num_r[Q_W-1]};
  assign rem_ge   = rem_sh >= (Q_W+1)'(X_DIV);
  assign x_val    = 16'({1'b0, num_r}) - 16'(X_OFS);

  // coefficient store, written straight from the input transfer
  assign coef_we = in_xfer && (in_ch.req_type == REQ_COEF) &&
                   ({3'b000, in_ch.coef_index} < 9'(TAPS));
  assign coef_raddr = AW'(cnt_r);

  fbyp_ram #(.WIDTH(COEF_W), .DEPTH(TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (AW'(in_ch.coef_index)),
    .wdata (in_ch.coef_value),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  // delay line as a circular buffer, newest entry at wptr_r
  assign dly_we = (state_r == ST_WRITE);

  fbyp_ram #(.WIDTH(COEF_W), .DEPTH(TAPS)) u_dly_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (wptr_nxt),
    .wdata (x_val),
    .raddr (rptr_r),
    .rdata (dly_rdata)
  );

  // output scaling: truncate toward zero on the divide by 2^Y_FRAC
  assign acc_sh = acc_r >>> ACC_SHIFT;
  assign y_val  = acc_sh[15:0];
  assign p_bias = p_r[P_W-1] ? p_r + P_W'((1 << Y_FRAC) - 1) : p_r;
  assign p_div  = p_bias >>> Y_FRAC;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    num_nxt   = num_r;
    dcnt_nxt  = dcnt_r;
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_ch.req_type == REQ_SAMPLE)) begin
          if (bypass_r) begin
            res_nxt   = DAC_W'(in_ch.sample);
            state_nxt = ST_FIN;
          end else begin
            rem_nxt   = num_full[NUM_W-1:Q_W];
            num_nxt   = num_full[Q_W-1:0];
            dcnt_nxt  = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        num_nxt  = {num_r[Q_W-2:0], rem_ge};
        rem_nxt  = rem_ge ? Q_W'(rem_sh - (Q_W+1)'(X_DIV)) : rem_sh[Q_W-1:0];
        dcnt_nxt = dcnt_r + 4'd1;
        if (dcnt_r == 4'(Q_W - 1)) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        wptr_nxt  = (wptr_r == AW'(TAPS - 1)) ? '0 : wptr_r + AW'(1);
        rptr_nxt  = wptr_nxt;
        if (fill_r != FW'(TAPS)) begin
          fill_nxt = fill_r + FW'(1);
        end
        cnt_nxt   = '0;
        acc_nxt   = '0;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        rptr_nxt = (rptr_r == '0) ? AW'(TAPS - 1) : rptr_r - AW'(1);
        cnt_nxt  = cnt_r + CW'(1);
        if (v2_r) begin
          acc_nxt = acc_r + ACC_W'(prod_r);
        end
        if (cnt_r == CW'(TAPS + 1)) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_nxt = ST_RND;
      end
      ST_RND: begin
        res_nxt   = DAC_W'(p_div + P_W'(DAC_MID));
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bypass_r    <= 1'b1;
      wptr_r      <= '0;
      fill_r      <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wptr_r  <= wptr_nxt;
      fill_r  <= fill_nxt;
      if (cfg_we) begin
        bypass_r <= cfg_wdata;
      end
      v1_r <= (state_r == ST_MAC) && (cnt_r < CW'(TAPS));
      v2_r <= v1_r;
      // hold the result until the sink takes it
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    num_r   <= num_nxt;
    dcnt_r  <= dcnt_nxt;
    rptr_r  <= rptr_nxt;
    cnt_r   <= cnt_nxt;
    acc_r   <= acc_nxt;
    res_r   <= res_nxt;
    live1_r <= (CW'(fill_r) > cnt_r);
    prod_r  <= live1_r ? $signed(coef_rdata) * $signed(dly_rdata) : 32'sd0;
    p_r     <= P_W'(y_val) * P_W'(DAC_GAIN);
    if (state_r == ST_FIN && out_free) begin
      out_data_r <= res_r;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fbyp_ram.sv -----
// ---------------------------------------------------------------------------
// fbyp_ram : generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fbyp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire                          clk,
  input  wire                          we,
  input  wire  [$clog2(DEPTH)-1:0]     waddr,
  input  wire  [WIDTH-1:0]             wdata,
  input  wire  [$clog2(DEPTH)-1:0]     raddr,
  output logic [WIDTH-1:0]             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write, then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- verif/fbyp_checker.sv -----
// ---------------------------------------------------------------------------
// fbyp_checker : DAC code predictor and scoreboard
// Watches the request and result channels and the bypass register write,
// predicts each DAC code and compares it with the transfers on the result
// channel. Hands the number of failures to the testbench top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module fbyp_checker (
  input  wire        clk,
  input  wire        rst_n,
  fbyp_in_if.sink    in_mon,
  fbyp_out_if.sink   out_mon,
  input  wire        cfg_we,
  input  wire        cfg_wdata,
  output int         fail_count,
  output int         pending
);
  import fbyp_pkg::*;

  localparam int NTAPS = TAPS_DEF;

  logic               bypass_q;
  logic signed [15:0] taps_q [NTAPS];
  logic signed [15:0] coefs_q [NTAPS];
  logic [15:0]        dac_fifo [$];

  assign pending = dac_fifo.size();

  // work out the DAC code for one filtered sample; delay line already advanced
  function automatic logic [15:0] filter_dac();
    logic signed [63:0] acc;
    logic signed [63:0] shifted;
    logic signed [15:0] y;
    logic signed [63:0] d;
    acc = 0;
    for (int i = 0; i < NTAPS; i++) acc += 64'(coefs_q[i]) * 64'(taps_q[i]);
    shifted = acc >>> ACC_SHIFT_DEF;
    y = shifted[15:0];
    d = (64'(y) * DAC_GAIN) / (64'sd1 <<< Y_FRAC_DEF) + DAC_MID;
    return d[15:0];
  endfunction

  always @(posedge clk) begin
    logic [15:0] got;
    logic [15:0] want;
    logic signed [31:0] x;
    if (!rst_n) begin
      bypass_q <= 1'b1;
      for (int i = 0; i < NTAPS; i++) begin
        taps_q[i] = '0;
        coefs_q[i] = '0;
      end
      dac_fifo.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) bypass_q <= cfg_wdata;
      // predict on each request transfer
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.req_type == REQ_COEF) begin
          if (in_mon.coef_index < NTAPS) coefs_q[in_mon.coef_index] = in_mon.coef_value;
        end else if (bypass_q) begin
          dac_fifo.push_back(16'(in_mon.sample));
        end else begin
          x = 32'((64'(in_mon.sample) * 270336) / 40950) - 13516;
          for (int i = NTAPS - 1; i > 0; i--) taps_q[i] = taps_q[i-1];
          taps_q[0] = x[15:0];
          dac_fifo.push_back(filter_dac());
        end
      end
      // compare each result transfer with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.dac_value;
        if (dac_fifo.size() == 0) begin
          $display("%0t: unexpected DAC code, expected none, actual %0d", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = dac_fifo.pop_front();
          if (got !== want) begin
            $display("%0t: dac_value mismatch, expected %0d, actual %0d", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- verif/fir_filter_with_bypass_test.sv -----
// ---------------------------------------------------------------------------
// fir_filter_with_bypass_test : testbench top for the FIR filter with bypass
// Loads the coefficients, runs directed and random samples in bypass and
// filter mode with random gaps and stalls, and reports the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module fir_filter_with_bypass_test;
  import fbyp_pkg::*;

  localparam int NTAPS = TAPS_DEF;
  localparam int DRAIN = NTAPS + 40;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  int   fail_count;
  int   pending;

  fbyp_in_if  in_ch ();
  fbyp_out_if out_ch ();

  fir_filter_with_bypass DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  fbyp_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard limit on the run
  initial begin
    #60ms;
    $display("fir_filter_with_bypass_test failed");
    $finish;
  end

  // result side: random stall before each transfer, sometimes none
  initial begin
    int   wait_cycles;
    logic calm;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      calm = ($urandom_range(0, 3) == 0);
      wait_cycles = calm ? 0 : $urandom_range(0, 19);
      if (wait_cycles != 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk iff out_ch.valid);
    end
  end

  // drive one request and hold it until its transfer; valid stays high
  // afterwards so that a request with no gap follows back to back
  task automatic send_req(input logic rt, input logic [11:0] smp,
                          input logic [5:0] idx, input logic signed [15:0] cv,
                          input int gap);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= rt;
    in_ch.sample     <= smp;
    in_ch.coef_index <= idx;
    in_ch.coef_value <= cv;
    @(posedge clk iff in_ch.ready);
  endtask

  function automatic int rand_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
  endfunction

  // let every expected code arrive, then allow the block to go quiet
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_bypass(input logic mode);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_coefs(input int style);
    logic signed [15:0] cv;
    for (int i = 0; i < NTAPS; i++) begin
      case (style)
        0: cv = 16'sh7fff;
        1: cv = 16'sh8000;
        2: cv = (i == 0) ? 16'sh7fff : 16'sd0;
        default: cv = 16'($urandom);
      endcase
      send_req(REQ_COEF, 12'($urandom), 6'(i), cv, rand_gap());
    end
  endtask

  initial begin
    logic [11:0] smp;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = REQ_SAMPLE;
    in_ch.sample     = '0;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b1;
    rst_n     = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: bypass extremes, then filter extremes with full-scale and single-tap coefficients
    send_req(REQ_SAMPLE, 12'd0, 6'd0, 16'sd0, 0);
    send_req(REQ_SAMPLE, 12'hfff, 6'h3f, -16'sd1, 0);
    send_req(REQ_SAMPLE, 12'h555, 6'd0, 16'sd0, 3);
    send_req(REQ_SAMPLE, 12'haaa, 6'd0, 16'sd0, 0);
    load_coefs(0);
    set_bypass(1'b0);
    send_req(REQ_SAMPLE, 12'hfff, 6'd0, 16'sd0, 0);
    send_req(REQ_SAMPLE, 12'hfff, 6'd0, 16'sd0, 0);
    send_req(REQ_SAMPLE, 12'd0, 6'd0, 16'sd0, 0);
    send_req(REQ_SAMPLE, 12'd2048, 6'd0, 16'sd0, 0);
    load_coefs(1);
    send_req(REQ_SAMPLE, 12'd0, 6'd0, 16'sd0, 0);
    send_req(REQ_SAMPLE, 12'hfff, 6'd0, 16'sd0, 0);
    load_coefs(2);
    send_req(REQ_SAMPLE, 12'd0, 6'd0, 16'sd0, 0);
    send_req(REQ_SAMPLE, 12'hfff, 6'd0, 16'sd0, 0);

    // random phases, alternating modes; sender pauses for an empty pipe at each
    for (int ph = 0; ph < 6; ph++) begin
      set_bypass(ph[0]);
      if (ph == 2) load_coefs(3);
      for (int n = 0; n < 130; n++) begin
        if ($urandom_range(0, 15) == 0) begin
          send_req(REQ_COEF, 12'($urandom), 6'($urandom), 16'($urandom), rand_gap());
        end else begin
          case ($urandom_range(0, 3))
            0: smp = $urandom_range(0, 1) ? 12'hfff : 12'd0;
            default: smp = 12'($urandom);
          endcase
          send_req(REQ_SAMPLE, smp, 6'($urandom), 16'($urandom), rand_gap());
        end
      end
    end

    drain_block();
    if (fail_count == 0) begin
      $display("fir_filter_with_bypass_test passed");
    end else begin
      $display("fir_filter_with_bypass_test failed");
    end
    $finish;
  end
endmodule
